// File: hdl/dtc_pkg.sv
// Shared types and constants for the decimal text to centimetres parser.
`default_nettype none
package dtc_pkg;

	localparam int MAG_W = 53;
	localparam int CM_W = 54;
	localparam int MAX_TEXT_DEF = 32;
	localparam logic [MAG_W-1:0] MAX_MAG_RESET = {MAG_W{1'b1}};

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [1:0] FRAC_PLACES = 2'd2;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_INT = 2'd1,
		PH_FRAC = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic is_last;
	} chr_req_t;

	typedef struct packed {
		logic signed [CM_W-1:0] centimetres;
		logic valid_res;
	} res_req_t;

	// snapshot of a finished text, handed to the scaling stage
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic neg;
		logic [1:0] frac_cnt;
		logic err;
	} fin_t;

endpackage
`default_nettype wire

// File: hdl/decimal_text_to_centimetres.sv
// Top level: decimal metre text parser giving signed centimetres.
// Throughput: one character per cycle; only a stalled result can hold off input.
// The last character's request passes the input register, the character stage and the
// scaling stage into the result register before res_valid rises; a stalled result can hold it.
// Reset clears the parse state and pipeline valids and loads the limit with 2^53-1.
// No clearing pass; the block takes characters right after reset.
`default_nettype none
module decimal_text_to_centimetres #(
	parameter int MAX_TEXT = dtc_pkg::MAX_TEXT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic chr_valid,
	output logic chr_ready,
	input wire dtc_pkg::chr_req_t chr,
	output logic res_valid,
	input wire logic res_ready,
	output dtc_pkg::res_req_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [dtc_pkg::MAG_W-1:0] cfg_data
);
	import dtc_pkg::*;

	localparam int CNT_W = $clog2(MAX_TEXT + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT);

	logic [MAG_W-1:0] max_mag_q;

	// pipeline control
	logic v_s1, v_s2, res_v_q;
	logic s1_go, s2_go;
	chr_req_t chr_s1;
	fin_t fin_s2;
	res_req_t res_q;

	// parse state
	phase_t phase_q, phase_nx;
	logic [MAG_W-1:0] acc_q, acc_nx;
	logic neg_q, neg_nx;
	logic has_int_q, has_int_nx;
	logic fdz_q, fdz_nx;
	logic [1:0] fcnt_q, fcnt_nx;
	logic lfz_q, lfz_nx;
	logic [CNT_W-1:0] cnt_q, cnt_nx;
	logic err_q, err_nx;

	logic is_digit;
	logic [3:0] dig;
	logic do_push;
	logic [MAG_W+3:0] prod;
	logic prod_ovf;
	logic fin_bad;
	fin_t fin_nx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mag_q <= MAX_MAG_RESET;
		end else if (cfg_valid) begin
			max_mag_q <= cfg_data;
		end
	end

	assign s2_go = v_s2 && (!res_v_q || res_ready);
	assign s1_go = v_s1 && (!chr_s1.is_last || !v_s2 || s2_go);
	assign chr_ready = !v_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (chr_valid && chr_ready) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go && chr_s1.is_last) begin
				v_s2 <= 1'b1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end
			if (s2_go) begin
				res_v_q <= 1'b1;
			end else if (res_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chr_valid && chr_ready) begin
			chr_s1 <= chr;
		end
		if (s1_go && chr_s1.is_last) begin
			fin_s2 <= fin_nx;
		end
	end

	// character decode and digit step
	assign is_digit = (chr_s1.char_code >= CHAR_ZERO) && (chr_s1.char_code <= CHAR_NINE);
	assign dig = is_digit ? 4'(chr_s1.char_code - CHAR_ZERO) : 4'd0;
	assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (MAG_W+4)'(dig);
	assign prod_ovf = prod > (MAG_W+4)'(max_mag_q);

	// next parse state
	always_comb begin
		phase_nx = phase_q;
		acc_nx = acc_q;
		neg_nx = neg_q;
		has_int_nx = has_int_q;
		fdz_nx = fdz_q;
		fcnt_nx = fcnt_q;
		lfz_nx = lfz_q;
		do_push = 1'b0;
		cnt_nx = (cnt_q <= CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		err_nx = err_q || (cnt_nx > CNT_MAX);
		if (!err_nx) begin
			unique case (phase_q)
				PH_START, PH_INT: begin
					if (is_digit) begin
						if (has_int_q && fdz_q) begin
							err_nx = 1'b1;
						end else begin
							if (!has_int_q) begin
								fdz_nx = (dig == 4'd0);
							end
							has_int_nx = 1'b1;
							phase_nx = PH_INT;
							do_push = 1'b1;
						end
					end else if (phase_q == PH_START && chr_s1.char_code == CHAR_MINUS) begin
						neg_nx = 1'b1;
						phase_nx = PH_INT;
					end else if (phase_q == PH_INT && chr_s1.char_code == CHAR_DOT
							&& has_int_q) begin
						phase_nx = PH_FRAC;
					end else begin
						err_nx = 1'b1;
					end
				end
				PH_FRAC: begin
					if (!is_digit || fcnt_q >= FRAC_PLACES) begin
						err_nx = 1'b1;
					end else begin
						fcnt_nx = fcnt_q + 2'd1;
						lfz_nx = (dig == 4'd0);
						do_push = 1'b1;
					end
				end
				default: begin
					err_nx = 1'b1;
				end
			endcase
		end
		if (do_push) begin
			if (prod_ovf) begin
				err_nx = 1'b1;
			end else begin
				acc_nx = prod[MAG_W-1:0];
			end
		end
	end

	// end-of-text grammar checks on the state after the last character
	always_comb begin
		unique case (phase_nx)
			PH_INT: fin_bad = !has_int_nx;
			PH_FRAC: fin_bad = (fcnt_nx == 2'd0) || lfz_nx;
			default: fin_bad = 1'b1;
		endcase
		fin_nx.mag = acc_nx;
		fin_nx.neg = neg_nx;
		fin_nx.frac_cnt = fcnt_nx;
		fin_nx.err = err_nx || fin_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q <= '0;
			neg_q <= 1'b0;
			has_int_q <= 1'b0;
			fdz_q <= 1'b0;
			fcnt_q <= '0;
			lfz_q <= 1'b0;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (s1_go) begin
			if (chr_s1.is_last) begin
				phase_q <= PH_START;
				acc_q <= '0;
				neg_q <= 1'b0;
				has_int_q <= 1'b0;
				fdz_q <= 1'b0;
				fcnt_q <= '0;
				lfz_q <= 1'b0;
				cnt_q <= '0;
				err_q <= 1'b0;
			end else begin
				phase_q <= phase_nx;
				acc_q <= acc_nx;
				neg_q <= neg_nx;
				has_int_q <= has_int_nx;
				fdz_q <= fdz_nx;
				fcnt_q <= fcnt_nx;
				lfz_q <= lfz_nx;
				cnt_q <= cnt_nx;
				err_q <= err_nx;
			end
		end
	end

	// pad missing fraction places; acc*100 covers both padding steps since it bounds acc*10
	logic [MAG_W+6:0] m10, m100, scaled;
	logic ok;
	logic [CM_W-1:0] mag_cm;
	res_req_t res_nx;

	assign m10 = {4'b0, fin_s2.mag, 3'b000} + {6'b0, fin_s2.mag, 1'b0};
	assign m100 = {1'b0, fin_s2.mag, 6'b0} + {2'b0, fin_s2.mag, 5'b0}
		+ {5'b0, fin_s2.mag, 2'b0};

	always_comb begin
		unique case (fin_s2.frac_cnt)
			2'd0: scaled = m100;
			2'd1: scaled = m10;
			default: scaled = (MAG_W+7)'(fin_s2.mag);
		endcase
		ok = !fin_s2.err && (scaled <= (MAG_W+7)'(max_mag_q));
		mag_cm = scaled[CM_W-1:0];
		res_nx.valid_res = ok;
		if (!ok) begin
			res_nx.centimetres = '0;
		end else if (fin_s2.neg) begin
			res_nx.centimetres = CM_W'(0) - mag_cm;
		end else begin
			res_nx.centimetres = mag_cm;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = res_v_q;
	assign res = res_q;

endmodule
`default_nettype wire

// File: hdl/dtc_chk.sv
// Port-level checker for the parser, bound to the top level.
`default_nettype none
module dtc_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic chr_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire dtc_pkg::res_req_t res
);
	import dtc_pkg::*;

	// a result waiting on the consumer keeps its contents
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// input side is only held off behind a stalled result
	a_chr_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> chr_ready)
		else $error("input stalled with no result pending");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.valid_res |-> res.centimetres == '0)
		else $error("invalid result carries a value");

	a_neg_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.centimetres[CM_W-1] |-> res.valid_res)
		else $error("negative value on invalid result");

endmodule

bind decimal_text_to_centimetres dtc_chk u_dtc_chk (
	.clk(clk),
	.arst_n(arst_n),
	.chr_ready(chr_ready),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res(res)
);
`default_nettype wire
